// File: sv/wbpm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbpm_pkg
// shared types and constants of the wildcard byte pattern matcher
// ----------------------------------------------------------------------------
package wbpm_pkg;

    localparam int MAX_PATTERN   = 32;
    localparam int OFFSET_BITS   = 32;
    localparam int DATA_BITS     = 8;
    localparam int COUNT_BITS    = 32;
    localparam int RES_OFF_BITS  = 32;
    localparam int LEN_BITS      = 6;
    localparam int POS_IDX_BITS  = $clog2(MAX_PATTERN);
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 64;
    localparam int BYTES_PER_REG = CFG_DATA_BITS / DATA_BITS;
    localparam int MASK_BITS     = 32;

    // register indexes of the configuration port
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_PAT_LO     = 3'd0,
        CFG_PAT_MID_LO = 3'd1,
        CFG_PAT_MID_HI = 3'd2,
        CFG_PAT_HI     = 3'd3,
        CFG_WILD_MASK  = 3'd4,
        CFG_PAT_LEN    = 3'd5,
        CFG_ALL_MATCH  = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [MAX_PATTERN-1:0][DATA_BITS-1:0] pattern;
        logic [MAX_PATTERN-1:0]                wild_mask;
        logic [LEN_BITS-1:0]                   pat_len;
        logic                                  all_matches;
    } t_cfg;

endpackage

// File: sv/wbpm_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbpm_in_if
// input channel: one stream byte per item
// ----------------------------------------------------------------------------
interface wbpm_in_if import wbpm_pkg::*; ();

    logic                 valid;
    logic                 ready;
    logic [DATA_BITS-1:0] data_byte;
    logic                 first_byte;

    modport source (output valid, output data_byte, output first_byte, input ready);
    modport sink   (input valid, input data_byte, input first_byte, output ready);

endinterface

// File: sv/wbpm_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbpm_out_if
// result channel: start offset and running count of a found match
// ----------------------------------------------------------------------------
interface wbpm_out_if import wbpm_pkg::*; ();

    logic                    valid;
    logic                    ready;
    logic [RES_OFF_BITS-1:0] match_offset;
    logic [COUNT_BITS-1:0]   match_count;

    modport source (output valid, output match_offset, output match_count, input ready);
    modport sink   (input valid, input match_offset, input match_count, output ready);

endinterface

// File: sv/wbpm_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbpm_cfg_regs
// configuration registers: pattern bytes, wildcard mask, length, mode
// ----------------------------------------------------------------------------
module wbpm_cfg_regs import wbpm_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_wdata,
    output t_cfg                     o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pattern     <= '0;
            r_cfg.wild_mask   <= '0;
            r_cfg.pat_len     <= LEN_BITS'(1);
            r_cfg.all_matches <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_PAT_LO:     r_cfg.pattern[0*BYTES_PER_REG +: BYTES_PER_REG] <= i_cfg_wdata;
                CFG_PAT_MID_LO: r_cfg.pattern[1*BYTES_PER_REG +: BYTES_PER_REG] <= i_cfg_wdata;
                CFG_PAT_MID_HI: r_cfg.pattern[2*BYTES_PER_REG +: BYTES_PER_REG] <= i_cfg_wdata;
                CFG_PAT_HI:     r_cfg.pattern[3*BYTES_PER_REG +: BYTES_PER_REG] <= i_cfg_wdata;
                CFG_WILD_MASK:  r_cfg.wild_mask <= i_cfg_wdata[MASK_BITS-1:0];
                CFG_PAT_LEN:    r_cfg.pat_len <= i_cfg_wdata[LEN_BITS-1:0];
                CFG_ALL_MATCH:  r_cfg.all_matches <= i_cfg_wdata[0];
                default: begin
                    // unused index, write dropped
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: sv/wbpm_match_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbpm_match_core
// input register, shift-and match update and result register
// ----------------------------------------------------------------------------
module wbpm_match_core import wbpm_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cfg  i_cfg,
    wbpm_in_if.sink    i_in,
    wbpm_out_if.source o_out
);

    // input stage
    logic                 r_in_valid;
    logic [DATA_BITS-1:0] r_in_data;
    logic                 r_in_first;

    // scan state
    logic [MAX_PATTERN-1:0] r_pm;
    logic [OFFSET_BITS-1:0] r_pos;
    logic [COUNT_BITS-1:0]  r_found;
    logic                   r_stopped;

    // result stage
    logic                    r_out_valid;
    logic [RES_OFF_BITS-1:0] r_out_offset;
    logic [COUNT_BITS-1:0]   r_out_count;

    logic                    out_free;
    logic                    consume;
    logic [LEN_BITS-1:0]     n_used;
    logic [POS_IDX_BITS-1:0] last_idx;
    logic [MAX_PATTERN-1:0]  len_mask;
    logic [MAX_PATTERN-1:0]  acc_vec;
    logic [MAX_PATTERN-1:0]  eff_pm;
    logic [OFFSET_BITS-1:0]  eff_pos;
    logic [COUNT_BITS-1:0]   eff_found;
    logic                    skip;
    logic [MAX_PATTERN-1:0]  shifted;
    logic                    hit;
    logic [MAX_PATTERN-1:0]  n_pm;
    logic [OFFSET_BITS-1:0]  n_pos;
    logic [COUNT_BITS-1:0]   n_found;
    logic                    n_stopped;
    logic [OFFSET_BITS-1:0]  start_pos;

    assign out_free   = !r_out_valid || o_out.ready;
    assign consume    = r_in_valid && out_free;
    assign i_in.ready = !r_in_valid || out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_data  <= i_in.data_byte;
            r_in_first <= i_in.first_byte;
        end
    end

    // length clamped to 1..MAX_PATTERN
    always_comb begin
        if (i_cfg.pat_len == '0) begin
            n_used = LEN_BITS'(1);
        end else if (i_cfg.pat_len > LEN_BITS'(MAX_PATTERN)) begin
            n_used = LEN_BITS'(MAX_PATTERN);
        end else begin
            n_used = i_cfg.pat_len;
        end
    end

    assign last_idx = POS_IDX_BITS'(n_used - LEN_BITS'(1));

    always_comb begin
        for (int i = 0; i < MAX_PATTERN; i++) begin
            len_mask[i] = (LEN_BITS'(i) < n_used);
            acc_vec[i]  = i_cfg.wild_mask[i] || (i_cfg.pattern[i] == r_in_data);
        end
    end

    always_comb begin
        eff_pm    = r_in_first ? '0 : r_pm;
        eff_pos   = r_in_first ? '0 : r_pos;
        eff_found = r_in_first ? '0 : r_found;
        skip      = !r_in_first && r_stopped;
        shifted   = {eff_pm[MAX_PATTERN-2:0], 1'b1} & acc_vec & len_mask;
        hit       = !skip && shifted[last_idx];
        start_pos = eff_pos - OFFSET_BITS'(n_used) + OFFSET_BITS'(1);
        if (skip) begin
            n_pm      = r_pm;
            n_pos     = r_pos;
            n_found   = r_found;
            n_stopped = r_stopped;
        end else begin
            n_pm      = hit ? '0 : shifted;
            n_pos     = eff_pos + OFFSET_BITS'(1);
            n_found   = (hit && (eff_found != '1)) ? eff_found + COUNT_BITS'(1) : eff_found;
            n_stopped = hit && !i_cfg.all_matches;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pm      <= '0;
            r_pos     <= '0;
            r_found   <= '0;
            r_stopped <= 1'b0;
        end else if (consume) begin
            r_pm      <= n_pm;
            r_pos     <= n_pos;
            r_found   <= n_found;
            r_stopped <= n_stopped;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (consume && hit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (consume && hit) begin
            r_out_offset <= RES_OFF_BITS'(start_pos);
            r_out_count  <= n_found;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.match_offset = r_out_offset;
    assign o_out.match_count  = r_out_count;

    // a held result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |-> !consume)
        else $error("result overwritten while stalled");

    // a found match clears every partial match
    a_hit_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (consume && hit) |=> (r_pm == '0))
        else $error("partial matches kept after a match");

    // a stopped scan counts nothing until a new scan starts
    a_stop_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (consume && r_stopped && !r_in_first) |=> ($stable(r_found) && !$rose(r_out_valid)))
        else $error("stopped scan produced a result");

    // a delivered count is never zero
    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_count != '0))
        else $error("zero match count");

endmodule

// File: sv/wildcard_byte_pattern_matcher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_matcher
// stream search for a byte pattern of up to 32 positions with wildcards
// ----------------------------------------------------------------------------
// The block takes one stream byte per item and reports each non-overlapping
// occurrence of the configured pattern as an item carrying the offset of its
// first byte and the running match count of the scan (saturating); with
// all_matches clear the scan stops after its first match. An item with
// first_byte set starts a new scan at offset zero. It accepts one item every
// clock cycle unless the result register stalls it: every pattern position
// is compared against the byte in parallel and the shift-and partial-match
// word is updated combinationally between the input and result registers,
// and the result register holds each result; bytes that complete no match
// produce no item. Backpressure on the result channel stalls the input only
// while the result register is full. The user must write configuration
// registers through the plain write port only while no item is in flight,
// which the block does not enforce; there is no clearing pass after reset.
// ----------------------------------------------------------------------------
module wildcard_byte_pattern_matcher import wbpm_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // configuration write port
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_wdata,
    // byte stream in, match items out
    wbpm_in_if.sink                  i_in,
    wbpm_out_if.source               o_out
);

    // live configuration seen by the match logic
    t_cfg cfg;

    wbpm_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    // input register, shift-and update, scan state and result register
    wbpm_match_core u_match_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_in    (i_in),
        .o_out   (o_out)
    );

endmodule
